### design/nlp_pkg.sv
// Package for the numeric literal parser: widths, codes, beat types and character helpers.
`default_nettype none
package nlp_pkg;

  // Width of the internal accumulator; the result value is its low 16 bits.
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned OUT_BITS   = 16;

  typedef logic [VALUE_BITS-1:0] val_t;

  // Characters the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Parse phases, one-hot.
  typedef enum logic [14:0] {
    PH_FIRST = 15'b000000000000001,
    PH_LOC   = 15'b000000000000010,
    PH_ZERO  = 15'b000000000000100,
    PH_BINF  = 15'b000000000001000,
    PH_BIN   = 15'b000000000010000,
    PH_DEC   = 15'b000000000100000,
    PH_HEXF  = 15'b000000001000000,
    PH_HEX   = 15'b000000010000000,
    PH_CHR   = 15'b000000100000000,
    PH_CHRQ  = 15'b000001000000000,
    PH_CHRB  = 15'b000010000000000,
    PH_CHRE  = 15'b000100000000000,
    PH_SYM   = 15'b001000000000000,
    PH_ESYN  = 15'b010000000000000,
    PH_ENAME = 15'b100000000000000
  } phase_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SYM  = 2'd1,
    ST_SYN  = 2'd2,
    ST_NAME = 2'd3
  } status_e;

  // Input beat: one character plus the location counter.
  typedef struct packed {
    logic [7:0]  char_code;
    logic [15:0] location_count;
  } in_t;

  // Output beat: parsed value and status.
  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    status_e             status;
  } out_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_alpha_u(logic [7:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
           (c == CH_UNDER);
  endfunction

  // Hex digit check; the digit value comes back in the low four bits.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (is_digit(c)) begin
      d = c - CH_0;
      return {1'b1, d[3:0]};
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - CH_UA + 8'd10;
      return {1'b1, d[3:0]};
    end else if ((c >= CH_LA) && (c <= CH_LF)) begin
      d = c - CH_LA + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // Low 16 bits of an accumulator value, zero-extended when it is narrower.
  function automatic logic [OUT_BITS-1:0] to_value(val_t v);
    logic [OUT_BITS-1:0] r;
    r = '0;
    for (int unsigned i = 0; i < OUT_BITS; i++) begin
      if (i < VALUE_BITS) r[i] = v[i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/numeric_literal_parser.sv
// Top level of the numeric literal parser: per-character state update and result register.
//
// Usage:
//   Feed one character of a token per input beat on in_data_i.char_code, with
//   the current location counter on in_data_i.location_count. A zero character
//   ends the token; only that beat yields an output beat, carrying the parsed
//   value and a status (ok, symbol needs lookup, syntax error, bad symbol name).
//   The value is zero whenever the status is not ok.
// Latency and throughput:
//   One character is taken every cycle while the result register can take a beat
//   (see Stalls). The result of a terminator appears in the output register on
//   the cycle after the terminator beat is accepted. It is selected by phase from
//   the accumulator register or the beat's location counter into the result register.
// Stalls:
//   The result register holds its beat until out_ready_i. While it is full,
//   input is still taken whenever the waiting beat leaves in the same cycle.
// Reset:
//   rst_ni clears the phase to start of token, the accumulator to zero and the
//   output register to empty.
`default_nettype none
module numeric_literal_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire nlp_pkg::in_t  in_data_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      nlp_pkg::out_t out_data_o
);

  nlp_pkg::phase_e phase_q, phase_d;
  nlp_pkg::val_t   acc_q, acc_d;
  logic            out_valid_q, out_valid_d;
  nlp_pkg::out_t   out_q, out_d;

  logic          in_acc;
  logic          term;
  logic [7:0]    c;
  logic [4:0]    hex_d;
  nlp_pkg::val_t digit_v;
  nlp_pkg::val_t acc_dec, acc_bin, acc_hex, acc_chr;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;
  assign c          = in_data_i.char_code;
  assign term       = (c == nlp_pkg::CH_NUL);
  assign hex_d      = nlp_pkg::hex_digit(c);

  // Candidate accumulator updates for each radix and for character packing.
  always_comb begin
    logic [7:0] dd;
    dd      = c - nlp_pkg::CH_0;
    digit_v = nlp_pkg::val_t'(dd[3:0]);
    acc_dec = (acc_q << 3) + (acc_q << 1) + digit_v;
    acc_bin = (acc_q << 1) + nlp_pkg::val_t'(c[0]);
    acc_hex = (acc_q << 4) + nlp_pkg::val_t'(hex_d[3:0]);
    acc_chr = (acc_q << 8) | nlp_pkg::val_t'(c);
  end

  // Phase transitions and accumulator update per character; a terminator returns to start of token.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    unique case (phase_q)
      nlp_pkg::PH_FIRST: begin
        if (c == nlp_pkg::CH_STAR) phase_d = nlp_pkg::PH_LOC;
        else if (c == nlp_pkg::CH_0) phase_d = nlp_pkg::PH_ZERO;
        else if (nlp_pkg::is_digit(c)) begin
          acc_d   = acc_dec;
          phase_d = nlp_pkg::PH_DEC;
        end else if (c == nlp_pkg::CH_QUOTE) phase_d = nlp_pkg::PH_CHR;
        else if (nlp_pkg::is_alpha_u(c)) phase_d = nlp_pkg::PH_SYM;
        else phase_d = nlp_pkg::PH_ESYN;
      end
      nlp_pkg::PH_ZERO: begin
        if (c == nlp_pkg::CH_LB || c == nlp_pkg::CH_UB) phase_d = nlp_pkg::PH_BINF;
        else if (c == nlp_pkg::CH_LX || c == nlp_pkg::CH_UX) phase_d = nlp_pkg::PH_HEXF;
        else if (nlp_pkg::is_digit(c)) begin
          acc_d   = acc_dec;
          phase_d = nlp_pkg::PH_DEC;
        end else phase_d = nlp_pkg::PH_ESYN;
      end
      nlp_pkg::PH_BINF, nlp_pkg::PH_BIN: begin
        if (c == nlp_pkg::CH_0 || c == nlp_pkg::CH_1) begin
          acc_d   = acc_bin;
          phase_d = nlp_pkg::PH_BIN;
        end else phase_d = nlp_pkg::PH_ESYN;
      end
      nlp_pkg::PH_DEC: begin
        if (nlp_pkg::is_digit(c)) acc_d = acc_dec;
        else phase_d = nlp_pkg::PH_ESYN;
      end
      nlp_pkg::PH_HEXF, nlp_pkg::PH_HEX: begin
        if (hex_d[4]) begin
          acc_d   = acc_hex;
          phase_d = nlp_pkg::PH_HEX;
        end else phase_d = nlp_pkg::PH_ESYN;
      end
      nlp_pkg::PH_CHR: begin
        if (c == nlp_pkg::CH_QUOTE) phase_d = nlp_pkg::PH_CHRQ;
        else begin
          acc_d   = acc_chr;
          phase_d = nlp_pkg::PH_CHRB;
        end
      end
      nlp_pkg::PH_CHRQ, nlp_pkg::PH_CHRE: begin
        // A doubled quote stands for one quote character.
        if (c == nlp_pkg::CH_QUOTE) begin
          acc_d   = acc_chr;
          phase_d = nlp_pkg::PH_CHRB;
        end else phase_d = nlp_pkg::PH_ESYN;
      end
      nlp_pkg::PH_CHRB: begin
        if (c == nlp_pkg::CH_QUOTE) phase_d = nlp_pkg::PH_CHRE;
        else acc_d = acc_chr;
      end
      nlp_pkg::PH_SYM: begin
        if (!(nlp_pkg::is_alpha_u(c) || nlp_pkg::is_digit(c))) phase_d = nlp_pkg::PH_ENAME;
      end
      nlp_pkg::PH_ESYN, nlp_pkg::PH_ENAME: begin
        // The first error sticks until the terminator.
      end
      default: begin
        // The location counter followed by more characters.
        phase_d = nlp_pkg::PH_ESYN;
      end
    endcase
    if (term) begin
      phase_d = nlp_pkg::PH_FIRST;
      acc_d   = '0;
    end
  end

  // Result of a terminator beat.
  always_comb begin
    out_d.value  = '0;
    out_d.status = nlp_pkg::ST_SYN;
    unique case (phase_q)
      nlp_pkg::PH_LOC: begin
        out_d.value  = nlp_pkg::to_value(nlp_pkg::val_t'(in_data_i.location_count));
        out_d.status = nlp_pkg::ST_OK;
      end
      nlp_pkg::PH_ZERO, nlp_pkg::PH_BIN, nlp_pkg::PH_DEC, nlp_pkg::PH_HEX,
      nlp_pkg::PH_CHRE: begin
        out_d.value  = nlp_pkg::to_value(acc_q);
        out_d.status = nlp_pkg::ST_OK;
      end
      nlp_pkg::PH_SYM:   out_d.status = nlp_pkg::ST_SYM;
      nlp_pkg::PH_ENAME: out_d.status = nlp_pkg::ST_NAME;
      default:           out_d.status = nlp_pkg::ST_SYN;
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc && term) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= nlp_pkg::PH_FIRST;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_acc && term) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A terminator returns the parser to start of token with a cleared accumulator.
  a_term_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && term |=> phase_q == nlp_pkg::PH_FIRST && acc_q == '0)
    else $error("parser state not cleared after terminator");

  // A terminator beat always fills the result register.
  a_term_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && term |=> out_valid_q)
    else $error("terminator produced no result");

  // Non-ok results carry a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != nlp_pkg::ST_OK |-> out_q.value == '0)
    else $error("nonzero value with non-ok status");

  // A syntax error holds until the terminator.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !term && phase_q == nlp_pkg::PH_ESYN |=> phase_q == nlp_pkg::PH_ESYN)
    else $error("syntax error phase left before terminator");

endmodule
`default_nettype wire
